// ----- rtl/mmuac_pkg.sv -----
// shared types, codes and helper functions of the mmu access check block
// no dependencies
package mmuac_pkg;

  typedef enum logic [1:0] {
    CMD_CHECK    = 2'd0,
    CMD_READ_FSR = 2'd1,
    CMD_READ_FAR = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_INSTR = 2'd1,
    CLS_DATA  = 2'd2
  } fault_cls_e;

  localparam logic [2:0] FT_NONE        = 3'd0;
  localparam logic [2:0] FT_INVALID     = 3'd1;
  localparam logic [2:0] FT_PROTECTION  = 3'd2;
  localparam logic [2:0] FT_PRIVILEGE   = 3'd3;
  localparam logic [2:0] FT_TRANSLATION = 3'd4;

  localparam logic [1:0] ET_EMPTY = 2'd0;
  localparam logic [1:0] ET_PTE   = 2'd2;

  localparam logic [7:0] ASI_USER_INSTR = 8'd8;
  localparam logic [7:0] ASI_SUP_INSTR  = 8'd9;
  localparam logic [7:0] ASI_USR_DATA   = 8'd10;
  localparam logic [7:0] ASI_SUP_DATA   = 8'd11;

  localparam logic [1:0] CFG_MMU_ENABLE       = 2'd0;
  localparam logic [1:0] CFG_NO_FAULT_MODE    = 2'd1;
  localparam logic [1:0] CFG_ALWAYS_CACHEABLE = 2'd2;

  localparam logic [2:0] ACC_DISABLED = 3'd3;

  typedef struct packed {
    logic [2:0] at;
    logic [2:0] ft;
  } perm_res_t;

  function automatic logic [2:0] access_type(logic [7:0] asi, logic store);
    logic [1:0] base;
    logic       known;
    begin
      known = 1'b1;
      base  = 2'd0;
      case (asi)
        ASI_USR_DATA:   base = 2'd0;
        ASI_SUP_DATA:   base = 2'd1;
        ASI_USER_INSTR: base = 2'd2;
        ASI_SUP_INSTR:  base = 2'd3;
        default:        known = 1'b0;
      endcase
      access_type = known ? {store, base} : 3'd0;
    end
  endfunction

  function automatic logic [2:0] check_fault(logic [2:0] at, logic [31:0] pte);
    logic [7:0] bits;
    logic [2:0] res;
    begin
      bits = 8'd1 << at;
      res  = FT_NONE;
      if (pte[1:0] == ET_EMPTY) begin
        res = FT_INVALID;
      end else if (pte[1:0] != ET_PTE) begin
        res = FT_TRANSLATION;
      end else begin
        case (pte[4:2])
          3'd0: res = |(bits & 8'hFC) ? FT_PROTECTION : FT_NONE;
          3'd1: res = |(bits & 8'hCC) ? FT_PROTECTION : FT_NONE;
          3'd2: res = |(bits & 8'hF0) ? FT_PROTECTION : FT_NONE;
          3'd3: res = FT_NONE;
          3'd4: res = |(bits & 8'hF3) ? FT_PROTECTION : FT_NONE;
          3'd5: res = |(bits & 8'hDC) ? FT_PROTECTION : FT_NONE;
          3'd6: begin
            if (|(bits & 8'hA0)) res = FT_PROTECTION;
            else res = |(bits & 8'h55) ? FT_PRIVILEGE : FT_NONE;
          end
          default: res = |(bits & 8'h55) ? FT_PRIVILEGE : FT_NONE;
        endcase
      end
      check_fault = res;
    end
  endfunction

endpackage

// ----- rtl/mmu_access_check_and_fault_record.sv -----
// top level: access check, address forming, fault status and address registers
// depends on mmuac_pkg and mmuac_perm_check
//
// Takes one beat per cycle and returns its result from an output register in
// the cycle after it is taken; a new beat is taken whenever that register is empty or
// its beat is taken in the same cycle, so the block sustains one access per
// clock. The permission check, address forming and fault recording are a
// single combinational pass from the input beat and the fault registers.
// Fault status and fault address are updated at the edge that accepts the
// beat, so back-to-back beats see each other's faults in order.
module mmu_access_check_and_fault_record (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic          cfg_data_i,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // virt_addr, space_id, is_store, is_atomic, is_fetch, entry_word, entry_level
  input  logic [79:0]   s_axis_tdata_i,
  // command
  input  logic [1:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // phys_addr, cacheable, access_rights, granted, trap, fault_code,
  // updated_entry, entry_write_back, read_data
  output logic [111:0]  m_axis_tdata_o
);

  logic        enable_q, nf_q, always_c_q;
  logic [17:0] fsr_q, fsr_d;
  logic [31:0] far_q, far_d;
  mmuac_pkg::fault_cls_e pend_q, pend_d;
  logic         out_valid_q;
  logic [111:0] out_q, out_d;

  logic [31:0] va, pte;
  logic [7:0]  asi;
  logic        store, atomic, fetch;
  logic [1:0]  level;
  mmuac_pkg::cmd_e cmd;
  logic        accept;

  mmuac_pkg::perm_res_t perm;
  mmuac_pkg::fault_cls_e cls;
  logic [17:0] fsr_new;
  logic [35:0] pa;
  logic [31:0] upd;
  logic        trap;

  logic [35:0] o_pa;
  logic        o_c, o_granted, o_trap, o_wb;
  logic [2:0]  o_acc, o_fc;
  logic [31:0] o_upd, o_rd;

  assign va     = s_axis_tdata_i[31:0];
  assign asi    = s_axis_tdata_i[39:32];
  assign store  = s_axis_tdata_i[40];
  assign atomic = s_axis_tdata_i[41];
  assign fetch  = s_axis_tdata_i[42];
  assign pte    = s_axis_tdata_i[74:43];
  assign level  = s_axis_tdata_i[76:75];
  assign cmd    = mmuac_pkg::cmd_e'(s_axis_tuser_i);

  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  mmuac_perm_check u_perm (
    .space_id_i   (asi),
    .is_store_i   (store),
    .is_atomic_i  (atomic),
    .entry_word_i (pte),
    .res_o        (perm)
  );

  always_comb begin
    cls     = fetch ? mmuac_pkg::CLS_INSTR : mmuac_pkg::CLS_DATA;
    fsr_new = {8'd0, level, perm.at, perm.ft, 1'b1, pend_q == cls};
    trap    = ~(nf_q && (asi != mmuac_pkg::ASI_SUP_INSTR));
    unique case (level)
      2'd3:    pa = {pte[31:8], va[11:0]};
      2'd2:    pa = {pte[31:14], va[17:0]};
      2'd1:    pa = {pte[31:20], va[23:0]};
      default: pa = {pte[31:28], va};
    endcase
    upd = pte | 32'h20 | (store ? 32'h40 : 32'h0);
  end

  always_comb begin
    fsr_d     = fsr_q;
    far_d     = far_q;
    pend_d    = pend_q;
    o_pa      = '0;
    o_c       = 1'b0;
    o_acc     = '0;
    o_granted = 1'b0;
    o_trap    = 1'b0;
    o_fc      = mmuac_pkg::FT_NONE;
    o_upd     = '0;
    o_wb      = 1'b0;
    o_rd      = '0;
    unique case (cmd)
      mmuac_pkg::CMD_READ_FSR: begin
        o_rd   = {14'd0, fsr_q};
        fsr_d  = '0;
        pend_d = mmuac_pkg::CLS_NONE;
      end
      mmuac_pkg::CMD_READ_FAR: begin
        o_rd = far_q;
      end
      mmuac_pkg::CMD_CHECK: begin
        if (!enable_q) begin
          o_pa      = {4'd0, va};
          o_c       = always_c_q;
          o_acc     = mmuac_pkg::ACC_DISABLED;
          o_granted = 1'b1;
        end else if (perm.ft != mmuac_pkg::FT_NONE) begin
          o_trap = trap;
          o_fc   = perm.ft;
          if (!(pend_q == mmuac_pkg::CLS_DATA && cls != mmuac_pkg::CLS_DATA)) begin
            fsr_d  = fsr_new;
            far_d  = va;
            pend_d = cls;
          end
        end else begin
          o_pa      = pa;
          o_c       = pte[7];
          o_acc     = pte[4:2];
          o_granted = 1'b1;
          o_upd     = upd;
          o_wb      = upd != pte;
        end
      end
      default: begin
      end
    endcase
    out_d = {2'd0, o_rd, o_wb, o_upd, o_fc, o_trap, o_granted, o_acc, o_c, o_pa};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      nf_q       <= 1'b0;
      always_c_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mmuac_pkg::CFG_MMU_ENABLE:       enable_q   <= cfg_data_i;
        mmuac_pkg::CFG_NO_FAULT_MODE:    nf_q       <= cfg_data_i;
        mmuac_pkg::CFG_ALWAYS_CACHEABLE: always_c_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsr_q       <= '0;
      far_q       <= '0;
      pend_q      <= mmuac_pkg::CLS_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fsr_q  <= fsr_d;
        far_q  <= far_d;
        pend_q <= pend_d;
      end
      if (accept) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

`ifndef ASSERT_OFF
  a_fav_matches_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsr_q[1] == (pend_q != mmuac_pkg::CLS_NONE))
    else $error("fault valid bit out of step with pending class");

  a_pending_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == mmuac_pkg::CLS_NONE) || (pend_q == mmuac_pkg::CLS_INSTR) ||
    (pend_q == mmuac_pkg::CLS_DATA))
    else $error("pending fault class holds an unused code");

  a_fsr_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd == mmuac_pkg::CMD_READ_FSR) |=> (fsr_q == '0))
    else $error("fault status not cleared after read");

  a_grant_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q[40] && (out_q[44:42] != mmuac_pkg::FT_NONE)))
    else $error("granted beat carries a fault code");
`endif

endmodule

// ----- rtl/mmuac_perm_check.sv -----
// acc by access type permission check, atomic accesses checked both ways
// depends on mmuac_pkg
module mmuac_perm_check (
  input  logic [7:0]            space_id_i,
  input  logic                  is_store_i,
  input  logic                  is_atomic_i,
  input  logic [31:0]           entry_word_i,
  output mmuac_pkg::perm_res_t  res_o
);

  logic [2:0] at_first, at_second;
  logic [2:0] ft_first, ft_second;

  always_comb begin
    at_first  = mmuac_pkg::access_type(space_id_i, is_store_i);
    at_second = mmuac_pkg::access_type(space_id_i, ~is_store_i);
    ft_first  = mmuac_pkg::check_fault(at_first, entry_word_i);
    ft_second = mmuac_pkg::check_fault(at_second, entry_word_i);
    res_o.at  = at_first;
    res_o.ft  = ft_first;
    if (is_atomic_i && (ft_first == mmuac_pkg::FT_NONE) &&
        (ft_second != mmuac_pkg::FT_NONE)) begin
      res_o.at = at_second;
      res_o.ft = ft_second;
    end
  end

endmodule
